[hdl/dmfp_pkg.sv]
// Shared types, parameters and byte constants for the dictionary member flag parser.
package dmfp_pkg;

    // Saturation bound of the inner-list nesting counter (1 to 255).
    localparam int MAX_NEST_DEPTH = 15;
    localparam int NEST_W         = $clog2(MAX_NEST_DEPTH + 1);

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int KEY_LEN = 17;
    localparam int KPOS_W  = $clog2(KEY_LEN + 1);

    localparam logic [7:0] KEY_TEXT [KEY_LEN] = '{
        "f", "o", "r", "c", "e", "-", "l", "o", "a", "d", "-", "a", "t", "-", "t", "o", "p"
    };

    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Byte class as seen by the member parser.
    typedef enum logic [2:0] {
        CLS_SEP,
        CLS_SPACE,
        CLS_SEMI,
        CLS_EQUAL,
        CLS_QMARK,
        CLS_ONE,
        CLS_ZERO,
        CLS_OTHER
    } t_cls;

    typedef struct packed {
        logic [7:0] data;
        t_cls       cls;
        logic       last;
    } t_token;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_KEY,
        PH_WS,
        PH_EQ,
        PH_QM,
        PH_VAL,
        PH_DEAD
    } t_phase;

    typedef enum logic [1:0] {
        CAND_NONE,
        CAND_TRUE,
        CAND_FALSE
    } t_cand;

endpackage

[hdl/dmfp_if.sv]
// Valid/ready channel interfaces for header bytes and flag results.
interface dmfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] header_byte;
    logic       last_byte;

    modport source (output valid, output header_byte, output last_byte, input ready);
    modport sink   (input valid, input header_byte, input last_byte, output ready);
endinterface

interface dmfp_out_if;
    logic valid;
    logic ready;
    logic load_at_top_flag;

    modport source (output valid, output load_at_top_flag, input ready);
    modport sink   (input valid, input load_at_top_flag, output ready);
endinterface

[hdl/dmfp_front.sv]
// Front end: tracks quoting and list nesting, classifies each byte into a token.
module dmfp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dmfp_in_if.sink         i_in,
    output logic            o_push_valid,
    input  logic            i_push_ready,
    output dmfp_pkg::t_token o_push_token
);
    import dmfp_pkg::*;

    logic              r_in_quote;
    logic              r_escape;
    logic [NEST_W-1:0] r_nest;
    logic              n_in_quote;
    logic              n_escape;
    logic [NEST_W-1:0] n_nest;
    logic              accept;
    logic              is_sep;
    t_cls              cls;

    assign accept       = i_in.valid && i_push_ready;
    assign i_in.ready   = i_push_ready;
    assign o_push_valid = i_in.valid;

    assign is_sep = !r_in_quote && (r_nest == '0) && (i_in.header_byte == CH_COMMA);

    always_comb begin
        if (is_sep) begin
            cls = CLS_SEP;
        end else begin
            unique case (i_in.header_byte) inside
                CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: cls = CLS_SPACE;
                CH_SEMI:  cls = CLS_SEMI;
                CH_EQUAL: cls = CLS_EQUAL;
                CH_QMARK: cls = CLS_QMARK;
                CH_ONE:   cls = CLS_ONE;
                CH_ZERO:  cls = CLS_ZERO;
                default:  cls = CLS_OTHER;
            endcase
        end
    end

    assign o_push_token = '{data: i_in.header_byte, cls: cls, last: i_in.last_byte};

    always_comb begin
        n_in_quote = r_in_quote;
        n_escape   = r_escape;
        n_nest     = r_nest;
        if (!is_sep) begin
            if (r_in_quote) begin
                if (r_escape) begin
                    n_escape = 1'b0;
                end else if (i_in.header_byte == CH_BSLASH) begin
                    n_escape = 1'b1;
                end else if (i_in.header_byte == CH_DQUOTE) begin
                    n_in_quote = 1'b0;
                end
            end else if (i_in.header_byte == CH_DQUOTE) begin
                n_in_quote = 1'b1;
            end else if (i_in.header_byte == CH_LPAREN) begin
                if (r_nest < NEST_W'(MAX_NEST_DEPTH)) begin
                    n_nest = r_nest + 1'b1;
                end
            end else if (i_in.header_byte == CH_RPAREN && r_nest != '0) begin
                n_nest = r_nest - 1'b1;
            end
        end
        // new header starts clean
        if (i_in.last_byte) begin
            n_in_quote = 1'b0;
            n_escape   = 1'b0;
            n_nest     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quote <= 1'b0;
            r_escape   <= 1'b0;
            r_nest     <= '0;
        end else if (accept) begin
            r_in_quote <= n_in_quote;
            r_escape   <= n_escape;
            r_nest     <= n_nest;
        end
    end

    a_nest_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nest <= NEST_W'(MAX_NEST_DEPTH))
        else $error("nesting count above bound");

    a_escape_in_quote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_escape |-> r_in_quote)
        else $error("escape pending outside a quoted string");

endmodule

[hdl/dmfp_queue.sv]
// Short token queue decoupling the front end from the member parser.
module dmfp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  dmfp_pkg::t_token i_push_token,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output dmfp_pkg::t_token o_pop_token
);
    import dmfp_pkg::*;

    t_token            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    function automatic logic [QPTR_W-1:0] f_ptr_next(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_token  = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop_ready && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= f_ptr_next(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= f_ptr_next(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hdl/dmfp_back.sv]
// Back end: per-member key match and value parse, flag update, result register.
module dmfp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_pop_valid,
    output logic             o_pop_ready,
    input  dmfp_pkg::t_token i_pop_token,
    dmfp_out_if.source       o_out
);
    import dmfp_pkg::*;

    t_phase            r_phase;
    t_phase            n_phase;
    logic [KPOS_W-1:0] r_key_pos;
    logic [KPOS_W-1:0] n_key_pos;
    t_cand             r_cand;
    t_cand             n_cand;
    logic              r_flag;
    logic              n_flag;
    logic              r_out_valid;
    logic              r_out_flag;
    logic              final_flag;
    logic              pop;

    // Flag value after closing a member in the given state.
    function automatic logic f_end_flag(input t_phase ph, input logic [KPOS_W-1:0] pos,
                                        input t_cand cand, input logic flag);
        logic res;
        res = flag;
        if (ph == PH_KEY && pos == KPOS_W'(KEY_LEN)) begin
            res = 1'b1;
        end else if ((ph == PH_VAL || ph == PH_WS) && cand != CAND_NONE) begin
            res = (cand == CAND_TRUE);
        end
        return res;
    endfunction

    assign o_pop_ready = !i_pop_token.last || !r_out_valid || o_out.ready;
    assign pop         = i_pop_valid && o_pop_ready;

    always_comb begin
        n_phase   = r_phase;
        n_key_pos = r_key_pos;
        n_cand    = r_cand;
        n_flag    = r_flag;
        if (i_pop_token.cls == CLS_SEP) begin
            n_flag    = f_end_flag(r_phase, r_key_pos, r_cand, r_flag);
            n_phase   = PH_LEAD;
            n_key_pos = '0;
            n_cand    = CAND_NONE;
        end else begin
            unique case (r_phase) inside
                PH_LEAD, PH_KEY: begin
                    if (r_phase == PH_LEAD && i_pop_token.cls == CLS_SPACE) begin
                        n_phase = PH_LEAD;
                    end else if (r_key_pos < KPOS_W'(KEY_LEN)) begin
                        // key position is zero while in the leading phase
                        if (i_pop_token.data == KEY_TEXT[r_key_pos]) begin
                            n_key_pos = r_key_pos + 1'b1;
                            n_phase   = PH_KEY;
                        end else begin
                            n_phase = PH_DEAD;
                        end
                    end else begin
                        case (i_pop_token.cls)
                            CLS_SEMI: begin
                                n_flag  = 1'b1;
                                n_phase = PH_DEAD;
                            end
                            CLS_EQUAL: n_phase = PH_EQ;
                            CLS_SPACE: begin
                                n_cand  = CAND_TRUE;
                                n_phase = PH_WS;
                            end
                            default: n_phase = PH_DEAD;
                        endcase
                    end
                end
                PH_WS: begin
                    if (i_pop_token.cls != CLS_SPACE) begin
                        n_phase = PH_DEAD;
                    end
                end
                PH_EQ: n_phase = (i_pop_token.cls == CLS_QMARK) ? PH_QM : PH_DEAD;
                PH_QM: begin
                    case (i_pop_token.cls)
                        CLS_ONE: begin
                            n_cand  = CAND_TRUE;
                            n_phase = PH_VAL;
                        end
                        CLS_ZERO: begin
                            n_cand  = CAND_FALSE;
                            n_phase = PH_VAL;
                        end
                        default: n_phase = PH_DEAD;
                    endcase
                end
                PH_VAL: begin
                    case (i_pop_token.cls)
                        CLS_SEMI: begin
                            n_flag  = (r_cand == CAND_TRUE);
                            n_phase = PH_DEAD;
                        end
                        CLS_SPACE: n_phase = PH_WS;
                        default:   n_phase = PH_DEAD;
                    endcase
                end
                default: n_phase = PH_DEAD;
            endcase
        end
        final_flag = f_end_flag(n_phase, n_key_pos, n_cand, n_flag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LEAD;
            r_key_pos <= '0;
            r_cand    <= CAND_NONE;
            r_flag    <= 1'b0;
        end else if (pop) begin
            if (i_pop_token.last) begin
                r_phase   <= PH_LEAD;
                r_key_pos <= '0;
                r_cand    <= CAND_NONE;
                r_flag    <= 1'b0;
            end else begin
                r_phase   <= n_phase;
                r_key_pos <= n_key_pos;
                r_cand    <= n_cand;
                r_flag    <= n_flag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop && i_pop_token.last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_pop_token.last) begin
            r_out_flag <= final_flag;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.load_at_top_flag = r_out_flag;

    a_last_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_pop_token.last) |=> r_out_valid)
        else $error("last byte consumed without a result word");

    a_header_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_pop_token.last) |=> (r_phase == PH_LEAD && !r_flag))
        else $error("member state not cleared after last byte");

    a_lead_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LEAD) |-> (r_key_pos == '0 && r_cand == CAND_NONE))
        else $error("leading phase with stale key position or candidate");

endmodule

[hdl/dictionary_member_flag_parser.sv]
// Top level: front classifier, token queue and member parser of the flag parser.
// Throughput: one byte per cycle; front and back take one word a cycle while no result waits.
// Result: the last byte's token passes through the token queue and is popped into the result
//   register, which sets the result word valid.
// A waiting result holds a following last byte at the queue head; the two-entry queue
//   then fills and stalls the input.
// Reset: synchronous, active low; clears quoting, nesting, member state, queue and result.
module dictionary_member_flag_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dmfp_in_if.sink    i_in,
    dmfp_out_if.source o_out
);
    import dmfp_pkg::*;

    logic   push_valid;
    logic   push_ready;
    t_token push_token;
    logic   pop_valid;
    logic   pop_ready;
    t_token pop_token;

    dmfp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_token (push_token)
    );

    dmfp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_token (push_token),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_token  (pop_token)
    );

    dmfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_token (pop_token),
        .o_out       (o_out)
    );

endmodule

[bench/dictionary_member_flag_parser_check.sv]
// Flag predictor and result checker for the dictionary member flag parser bench.
`timescale 1ns / 1ps
module dictionary_member_flag_parser_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_header_byte,
    input  logic       i_last_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_load_at_top_flag,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked,
    output int         o_set_count
);
    import dmfp_pkg::*;

    t_phase            phase;
    t_cand             cand;
    logic              quoted;
    logic              escaped;
    logic              flag;
    logic [NEST_W-1:0] depth;
    logic [KPOS_W-1:0] kpos;
    logic              expected_flags[$];

    int fail_count = 0;
    int pending_n  = 0;
    int checked_n  = 0;
    int set_n      = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_n;
    assign o_checked    = checked_n;
    assign o_set_count  = set_n;

    function automatic logic is_ws(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_LF ||
               b == CH_VT || b == CH_FF || b == CH_CR;
    endfunction

    task automatic clear_header();
        quoted  = 1'b0;
        escaped = 1'b0;
        depth   = '0;
        flag    = 1'b0;
        phase   = PH_LEAD;
        kpos    = '0;
        cand    = CAND_NONE;
    endtask

    task automatic close_member();
        if (phase == PH_KEY && kpos == KPOS_W'(KEY_LEN)) begin
            flag = 1'b1;
        end else if ((phase == PH_VAL || phase == PH_WS) && cand != CAND_NONE) begin
            flag = (cand == CAND_TRUE);
        end
        phase = PH_LEAD;
        kpos  = '0;
        cand  = CAND_NONE;
    endtask

    // One byte of a member, after the top-level split.
    task automatic member_byte(input logic [7:0] b);
        if (phase == PH_LEAD && !is_ws(b)) begin
            phase = PH_KEY;
            kpos  = '0;
        end
        case (phase)
            PH_LEAD: ;
            PH_KEY: begin
                if (kpos < KEY_LEN) begin
                    if (b == KEY_TEXT[kpos]) kpos = kpos + 1'b1;
                    else phase = PH_DEAD;
                end else if (b == CH_SEMI) begin
                    flag  = 1'b1;
                    phase = PH_DEAD;
                end else if (b == CH_EQUAL) begin
                    phase = PH_EQ;
                end else if (is_ws(b)) begin
                    cand  = CAND_TRUE;
                    phase = PH_WS;
                end else begin
                    phase = PH_DEAD;
                end
            end
            PH_WS: begin
                if (!is_ws(b)) phase = PH_DEAD;
            end
            PH_EQ: begin
                phase = (b == CH_QMARK) ? PH_QM : PH_DEAD;
            end
            PH_QM: begin
                if (b == CH_ONE) begin
                    cand  = CAND_TRUE;
                    phase = PH_VAL;
                end else if (b == CH_ZERO) begin
                    cand  = CAND_FALSE;
                    phase = PH_VAL;
                end else begin
                    phase = PH_DEAD;
                end
            end
            PH_VAL: begin
                if (b == CH_SEMI) begin
                    flag  = (cand == CAND_TRUE);
                    phase = PH_DEAD;
                end else if (is_ws(b)) begin
                    phase = PH_WS;
                end else begin
                    phase = PH_DEAD;
                end
            end
            default: phase = PH_DEAD;
        endcase
    endtask

    task automatic take_byte(input logic [7:0] b, input logic lst);
        if (!quoted && depth == 0 && b == CH_COMMA) begin
            close_member();
        end else begin
            if (quoted) begin
                if (escaped) escaped = 1'b0;
                else if (b == CH_BSLASH) escaped = 1'b1;
                else if (b == CH_DQUOTE) quoted = 1'b0;
            end else if (b == CH_DQUOTE) begin
                quoted = 1'b1;
            end else if (b == CH_LPAREN) begin
                // nesting count saturates
                if (depth < MAX_NEST_DEPTH) depth = depth + 1'b1;
            end else if (b == CH_RPAREN && depth != 0) begin
                depth = depth - 1'b1;
            end
            member_byte(b);
        end
        if (lst) begin
            close_member();
            expected_flags.push_back(flag);
            if (flag) set_n++;
            clear_header();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_header();
            expected_flags.delete();
        end else begin
            // results trail their last byte, so check before taking this edge's word
            if (i_out_valid && i_out_ready) begin
                if (expected_flags.size() == 0) begin
                    $error("result word with no header pending: load_at_top_flag=%0b",
                           i_load_at_top_flag);
                    fail_count++;
                end else begin
                    logic exp_flag;
                    exp_flag = expected_flags.pop_front();
                    checked_n++;
                    if (i_load_at_top_flag !== exp_flag) begin
                        $error("load_at_top_flag mismatch: expected %0b, actual %0b",
                               exp_flag, i_load_at_top_flag);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) take_byte(i_header_byte, i_last_byte);
        end
        pending_n = expected_flags.size();
    end

endmodule

[bench/dictionary_member_flag_parser_tb.sv]
// Top of the dictionary member flag parser bench: clock, reset, header stimulus and verdict.
`timescale 1ns / 1ps
module dictionary_member_flag_parser_tb;
    import dmfp_pkg::*;

    logic i_clk;
    logic i_rst_n;

    dmfp_in_if  in_ch ();
    dmfp_out_if out_ch ();

    int fail_count;
    int pending;
    int checked;
    int set_count;

    int n_bytes   = 0;
    int n_headers = 0;

    logic [7:0] hdr[$];

    dictionary_member_flag_parser u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    dictionary_member_flag_parser_check u_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_ch.valid),
        .i_in_ready         (in_ch.ready),
        .i_header_byte      (in_ch.header_byte),
        .i_last_byte        (in_ch.last_byte),
        .i_out_valid        (out_ch.valid),
        .i_out_ready        (out_ch.ready),
        .i_load_at_top_flag (out_ch.load_at_top_flag),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_checked          (checked),
        .o_set_count        (set_count)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) hdr.push_back(s[i]);
    endtask

    task automatic add_ws(input int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0: hdr.push_back(CH_SPACE);
                1: hdr.push_back(CH_TAB);
                2: hdr.push_back(CH_LF);
                3: hdr.push_back(CH_VT);
                4: hdr.push_back(CH_FF);
                default: hdr.push_back(CH_CR);
            endcase
        end
    endtask

    task automatic add_member();
        string key;
        int    kind;
        int    p;
        logic [7:0] c;
        key  = "force-load-at-top";
        kind = $urandom_range(0, 19);
        add_ws($urandom_range(0, 2));
        case (kind)
            10: add_str(key.substr(0, $urandom_range(0, 15)));
            11: begin
                p = $urandom_range(0, KEY_LEN - 1);
                for (int i = 0; i < KEY_LEN; i++) begin
                    c = (i == p) ? 8'($urandom_range(0, 255)) : key[i];
                    hdr.push_back(c);
                end
            end
            12: add_str({key, "s"});
            13: begin
                add_str("a");
                for (int i = 0; i < $urandom_range(0, 6); i++)
                    hdr.push_back(8'($urandom_range(97, 122)));
            end
            14: ;
            15: begin
                for (int i = 0; i < $urandom_range(1, 8); i++)
                    hdr.push_back(8'($urandom_range(0, 255)));
            end
            16: begin
                // deep nesting, at times past the counter bound
                add_str("x");
                for (int i = 0; i < $urandom_range(12, 20); i++) hdr.push_back(CH_LPAREN);
                for (int i = 0; i < $urandom_range(0, 20); i++) hdr.push_back(CH_RPAREN);
            end
            17: add_str($urandom_range(0, 1) ? ")" : "))");
            18: add_str("\"a,b\\\",c\"");
            19: add_str("(force-load-at-top, force-load-at-top=?0)");
            default: add_str(key);
        endcase
        if (kind <= 13) begin
            case ($urandom_range(0, 15))
                0: ;
                1: add_str($urandom_range(0, 1) ? ";p" : ";s=\"a\\\"b,c\"");
                2: add_str("=?1");
                3: add_str("=?0");
                4: add_str("=?1;a");
                5: add_str("=?0;q=\"x,y\"");
                6: add_str("=?1 ");
                7: add_str("=?0\t");
                8: begin
                    add_str("=?");
                    hdr.push_back(8'($urandom_range(0, 255)));
                end
                9: begin
                    add_str("=");
                    hdr.push_back(8'($urandom_range(0, 255)));
                end
                10: add_str("=?1x");
                11: add_str(" ");
                12: add_str(" x");
                13: begin
                    for (int i = 0; i < $urandom_range(1, 4); i++)
                        hdr.push_back(8'($urandom_range(0, 255)));
                end
                14: add_str("=?0 ;");
                default: add_str("=(a, \"b,c\" (d));l=(1,2)");
            endcase
        end
        add_ws($urandom_range(0, 2));
    endtask

    task automatic build_header();
        int members;
        hdr.delete();
        members = $urandom_range(1, 4);
        for (int k = 0; k < members; k++) begin
            if (k != 0) hdr.push_back(CH_COMMA);
            add_member();
        end
        // now and then leave a string or list open at the end
        case ($urandom_range(0, 19))
            0: add_str("\"open");
            1: add_str("(open");
            2: add_str(" \"\\");
            default: ;
        endcase
        if (hdr.size() == 0) hdr.push_back(CH_COMMA);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic lst, input bit quiet);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.header_byte <= b;
        in_ch.last_byte   <= lst;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        n_bytes++;
    endtask

    task automatic send_header();
        bit quiet;
        quiet = ($urandom_range(0, 3) == 0);
        foreach (hdr[i]) send_byte(hdr[i], i == hdr.size() - 1, quiet);
        n_headers++;
    endtask

    task automatic send_text(input string s);
        hdr.delete();
        add_str(s);
        send_header();
    endtask

    task automatic send_single(input logic [7:0] b);
        hdr.delete();
        hdr.push_back(b);
        send_header();
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.header_byte <= 8'h00;
        in_ch.last_byte   <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_single(8'h00);
        send_single(8'hFF);
        send_text(",");
        send_text(")");
        send_text("(");
        send_text("\"");
        send_text("force-load-at-top");

        while (n_bytes < 1150) begin
            build_header();
            send_header();
        end
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d header bytes in %0d headers; %0d flag words checked, %0d set.",
                 n_bytes, n_headers, checked, set_count);
        $display("Headers mixed key forms, quoted and nested commas, deep nesting and noise.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Result side: random stalls, plus two long hold-offs so the block backs up.
    initial begin
        int run;
        int hold;
        int r;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        for (int k = 0; ; k++) begin
            run = $urandom_range(1, 20);
            r   = $urandom_range(0, 99);
            if (k == 30 || k == 150) hold = 400;
            else if (r < 60) hold = 0;
            else if (r < 92) hold = $urandom_range(1, 4);
            else hold = $urandom_range(10, 40);
            out_ch.ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
hdl/dmfp_pkg.sv
hdl/dmfp_if.sv
hdl/dmfp_front.sv
hdl/dmfp_queue.sv
hdl/dmfp_back.sv
hdl/dictionary_member_flag_parser.sv
bench/dictionary_member_flag_parser_check.sv
bench/dictionary_member_flag_parser_tb.sv
